// ===== rtl/ctw_pkg.sv =====
`default_nettype none

package ctw_pkg;

    localparam int REG_BITS = 17;
    localparam int CFG_IDX_BITS = 3;

    localparam int MAX_RECORD_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COS_TABLE_ENTRIES_DEF = 256;

    localparam logic [REG_BITS-1:0] ONE_Q16 = 17'h10000;
    localparam int WEIGHT_BITS = REG_BITS + 1;
    localparam int FRAC_BITS = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_RECORD_LENGTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RISE_START = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RISE_END = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FALL_START = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FALL_END = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LOOK,
        S_MUL,
        S_SCALE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic zero;
        logic rise;
        logic fall;
    } t_ramp_flags;

endpackage

`default_nettype wire

// ===== rtl/ctw_in_if.sv =====
`default_nettype none

interface ctw_in_if
    import ctw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/ctw_out_if.sv =====
`default_nettype none

interface ctw_out_if
    import ctw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          record_last;

    modport source (output valid, output sample_out, output record_last, input ready);
    modport sink (input valid, input sample_out, input record_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ctw_divider.sv =====
`default_nettype none

module ctw_divider
    import ctw_pkg::*;
#(
    parameter int COS_ENTRIES = COS_TABLE_ENTRIES_DEF,
    localparam int TWO_Q = 2 * COS_ENTRIES,
    localparam int QB = $clog2(TWO_Q)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [REG_BITS-1:0] i_k,
    input  wire logic [REG_BITS-1:0] i_den,
    output      logic                o_done,
    output      logic [QB-1:0]       o_quot
);

    localparam int NB = REG_BITS + QB;
    localparam int CB = $clog2(QB + 1);

    logic [NB-1:0]       w_num;
    logic [REG_BITS:0]   w_trial;
    logic                w_fit;
    logic [REG_BITS-1:0] r_rem;
    logic [QB-1:0]       r_rest;
    logic [QB-1:0]       r_quot;
    logic [REG_BITS-1:0] r_den;
    logic [CB-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    assign w_num = NB'({{QB{1'b0}}, i_k} * NB'(TWO_Q));
    assign w_trial = {r_rem, r_rest[QB-1]};
    assign w_fit = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CB'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_num[NB-1:QB];
            r_rest <= w_num[QB-1:0];
            r_den <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? REG_BITS'(w_trial - {1'b0, r_den}) : w_trial[REG_BITS-1:0];
            r_rest <= {r_rest[QB-2:0], 1'b0};
            r_quot <= {r_quot[QB-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/ctw_cos_rom.sv =====
`default_nettype none

module ctw_cos_rom
    import ctw_pkg::*;
#(
    parameter int COS_ENTRIES = COS_TABLE_ENTRIES_DEF,
    localparam int AB = $clog2(COS_ENTRIES + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [AB-1:0]       i_addr,
    output      logic [REG_BITS-1:0] o_data
);

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TWO_Q = 64'(2 * COS_ENTRIES);
    localparam longint unsigned TERM_DIV [14] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
        64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
    };

    // Quarter-wave cosine in Q1.16 from a fixed-point Taylor series.
    function automatic logic [REG_BITS-1:0] cos_entry(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        x = (PI_Q30 * 64'(j)) / TWO_Q;
        x2 = (x * x) >> 30;
        sum = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int n = 0; n < 14; n++) begin
            term = (term * x2) >> 30;
            term = term / TERM_DIV[n];
            if (n % 2 == 1) begin
                sum = sum + longint'(term);
            end else begin
                sum = sum - longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 64'sd8192) >>> 14;
        if (r > 64'sd65536) begin
            r = 64'sd65536;
        end
        return REG_BITS'(r);
    endfunction

    logic [REG_BITS-1:0] w_tab [COS_ENTRIES+1];
    logic [REG_BITS-1:0] r_data;

    for (genvar g = 0; g <= COS_ENTRIES; g++) begin : g_entry
        localparam logic [REG_BITS-1:0] ENTRY = cos_entry(g);
        assign w_tab[g] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/ctw_scaler.sv =====
`default_nettype none

module ctw_scaler
    import ctw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x,
    input  wire logic        [WEIGHT_BITS-1:0] i_w,
    output      logic signed [SAMPLE_BITS-1:0] o_y
);

    localparam int PW = SAMPLE_BITS + WEIGHT_BITS + 1;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] w_round;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_x * $signed({1'b0, i_w}));
        end
    end

    // Adding one half and shifting arithmetically rounds ties toward plus infinity.
    assign w_round = (r_prod + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign o_y = w_round[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/cosine_taper_window_top.sv =====
`default_nettype none

// Channel        Direction  Payload                       Handshake
// i_sample_ch    in         sample_in                     valid / ready
// o_sample_ch    out        sample_out, record_last       valid / ready
// i_cfg_*        in         index, 17-bit data            write enable
//
// Each sample passes through the shared phase divider once for each ramp it lies in,
// and QB = log2(2 * COS_TABLE_ENTRIES) is the step count of that divider.
// Reset is synchronous and active low; no clearing pass is needed.
// A finished sample waits in the output register while the next one is accepted,
// and a full output register holds the block in its last state.
module cosine_taper_window_top
    import ctw_pkg::*;
#(
    parameter int MAX_RECORD = MAX_RECORD_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [REG_BITS-1:0]     i_cfg_data,
    ctw_in_if.sink                       i_sample_ch,
    ctw_out_if.source                    o_sample_ch
);

    localparam int QB = $clog2(2 * COS_TABLE_ENTRIES);
    localparam int AB = $clog2(COS_TABLE_ENTRIES + 1);
    localparam int LW = ($clog2(MAX_RECORD + 1) > REG_BITS + 1) ?
                        $clog2(MAX_RECORD + 1) : REG_BITS + 1;

    t_state r_state;
    t_state n_state;

    logic [REG_BITS-1:0] r_record_length;
    logic [REG_BITS-1:0] r_rise_start;
    logic [REG_BITS-1:0] r_rise_end;
    logic [REG_BITS-1:0] r_fall_start;
    logic [REG_BITS-1:0] r_fall_end;
    logic [REG_BITS-1:0] r_position;
    logic [REG_BITS-1:0] r_cur;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;
    logic                          r_sel;
    logic                          r_fall_act;
    logic                          r_neg;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_last;

    logic in_accept;
    logic div_start;
    logic rom_en;
    logic mul_en;
    logic out_load;

    t_ramp_flags         w_flags;
    logic [LW-1:0]       w_len;
    logic [LW-1:0]       w_len_raw;
    logic                w_last;
    logic [REG_BITS-1:0] w_k;
    logic [REG_BITS-1:0] w_den;
    logic                w_div_done;
    logic [QB-1:0]       w_quot;
    logic [QB:0]         w_j;
    logic [AB-1:0]       w_addr;
    logic                w_neg;
    logic [REG_BITS-1:0] w_cos;
    logic [WEIGHT_BITS-1:0] w_weight;
    logic signed [SAMPLE_BITS-1:0] w_scaled;

    always_comb begin
        w_flags.zero = (r_cur < r_rise_start) || (r_cur >= r_fall_end);
        w_flags.rise = (r_rise_end > r_rise_start) && (r_cur < r_rise_end);
        w_flags.fall = (r_fall_end > r_fall_start) && (r_cur >= r_fall_start);
    end

    always_comb begin
        w_len_raw = (r_record_length == '0) ? LW'(1) : LW'(r_record_length);
        w_len = (w_len_raw > LW'(MAX_RECORD)) ? LW'(MAX_RECORD) : w_len_raw;
        w_last = (LW'(r_cur) + LW'(1)) >= w_len;
    end

    assign w_k = r_sel ? (r_cur - r_fall_start) : (r_cur - r_rise_start);
    assign w_den = r_sel ? (r_fall_end - r_fall_start) : (r_rise_end - r_rise_start);

    always_comb begin
        w_j = {1'b0, w_quot};
        if (w_j >= (QB+1)'(2 * COS_TABLE_ENTRIES)) begin
            w_j = (QB+1)'(2 * COS_TABLE_ENTRIES - 1);
        end
        w_neg = w_j > (QB+1)'(COS_TABLE_ENTRIES);
        if (w_neg) begin
            w_addr = AB'((QB+1)'(2 * COS_TABLE_ENTRIES) - w_j);
        end else begin
            w_addr = AB'(w_j);
        end
    end

    // The rising ramp weight is one minus the signed cosine, the falling one plus it.
    always_comb begin
        if (r_sel ^ r_neg) begin
            w_weight = WEIGHT_BITS'({1'b0, ONE_Q16}) + WEIGHT_BITS'({1'b0, w_cos});
        end else begin
            w_weight = WEIGHT_BITS'({1'b0, ONE_Q16}) - WEIGHT_BITS'({1'b0, w_cos});
        end
    end

    ctw_divider #(
        .COS_ENTRIES(COS_TABLE_ENTRIES)
    ) u_divider (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_k(w_k),
        .i_den(w_den),
        .o_done(w_div_done),
        .o_quot(w_quot)
    );

    ctw_cos_rom #(
        .COS_ENTRIES(COS_TABLE_ENTRIES)
    ) u_cos_rom (
        .i_clk(i_clk),
        .i_en(rom_en),
        .i_addr(w_addr),
        .o_data(w_cos)
    );

    ctw_scaler #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scaler (
        .i_clk(i_clk),
        .i_en(mul_en),
        .i_x(r_x),
        .i_w(w_weight),
        .o_y(w_scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        in_accept = 1'b0;
        div_start = 1'b0;
        rom_en = 1'b0;
        mul_en = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_accept = i_sample_ch.valid;
                if (i_sample_ch.valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_flags.zero) begin
                    n_state = S_OUT;
                end else if (w_flags.rise || w_flags.fall) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                rom_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                mul_en = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                if (!r_sel && r_fall_act) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_sample_ch.ready) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_length <= ONE_Q16;
            r_rise_start <= '0;
            r_rise_end <= '0;
            r_fall_start <= ONE_Q16;
            r_fall_end <= ONE_Q16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RECORD_LENGTH: r_record_length <= i_cfg_data;
                REG_RISE_START: r_rise_start <= i_cfg_data;
                REG_RISE_END: r_rise_end <= i_cfg_data;
                REG_FALL_START: r_fall_start <= i_cfg_data;
                REG_FALL_END: r_fall_end <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
        end else if (r_state == S_CHECK) begin
            r_position <= w_last ? '0 : r_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x <= i_sample_ch.sample_in;
            r_cur <= r_position;
        end
        if (r_state == S_CHECK) begin
            r_last <= w_last;
            r_sel <= !w_flags.rise;
            r_fall_act <= w_flags.fall;
            if (w_flags.zero) begin
                r_x <= '0;
            end
        end
        if (rom_en) begin
            r_neg <= w_neg;
        end
        if (r_state == S_SCALE) begin
            r_x <= w_scaled;
            if (!r_sel && r_fall_act) begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_sample_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= r_x;
            r_out_last <= r_last;
        end
    end

    assign i_sample_ch.ready = (r_state == S_IDLE);
    assign o_sample_ch.valid = r_out_valid;
    assign o_sample_ch.sample_out = r_out_sample;
    assign o_sample_ch.record_last = r_out_last;

endmodule

`default_nettype wire
